/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files of the TapeAlert log page filter.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define CHECK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/tlpf_pkg.sv */
// Package of the TapeAlert log page filter: sizes, page constants, status codes,
// register indexes and the parse summary passed from parser to result stage.
// Depends on nothing.
package tlpf_pkg;

	localparam int PAGE_BYTES = 256;
	localparam int MAX_FLAGS  = 64;

	localparam int BYTE_W    = 8;
	localparam int MEDIA_W   = 48;
	localparam int FLAGS_W   = 64;
	localparam int COUNT_W   = 7;
	localparam int LEN_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = $clog2(PAGE_BYTES + 1);
	localparam int IDX_W     = $clog2(MAX_FLAGS + 1);

	localparam logic [BYTE_W-1:0] PAGE_CODE = 8'h2e;

	// Bit positions of the cleaning related alert flags (flag n is bit n-1).
	localparam int BIT_CLEAN_NOW      = 19;
	localparam int BIT_CLEAN_PERIODIC = 20;
	localparam int BIT_EXPIRED_MEDIA  = 21;
	localparam int BIT_INVALID_MEDIA  = 22;
	localparam int BIT_VENDOR_CLEAN   = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_ALERT_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTOCLEAN_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_CLEAN_BIT = 2'd2;

	typedef enum logic [2:0] {
		ST_NEW_ALERTS  = 3'd0,
		ST_DISABLED    = 3'd1,
		ST_NONE_ACTIVE = 3'd2,
		ST_ALREADY_SEEN = 3'd3,
		ST_SHORT       = 3'd4,
		ST_BAD_CODE    = 3'd5,
		ST_SEQ_ERROR   = 3'd6
	} status_t;

	// Page state as it stands after the byte being consumed.
	typedef struct packed {
		logic               short_page;
		logic               code_ok;
		logic               seq_err;
		logic [IDX_W-1:0]   count;
		logic [FLAGS_W-1:0] flags;
	} parse_sum_t;

endpackage

/* sv/tlpf_parser.sv */
// Byte-wise parser of one TapeAlert log page: header checks and 5-byte flag parameters.
// Depends on tlpf_pkg.
module tlpf_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic                           last,
	input  logic [tlpf_pkg::BYTE_W-1:0]    page_byte,
	output tlpf_pkg::parse_sum_t           sum
);
	import tlpf_pkg::*;

	typedef enum logic [2:0] {
		PB_CODE_HI,
		PB_CODE_LO,
		PB_CONTROL,
		PB_LENGTH,
		PB_VALUE
	} pbyte_t;

	logic [POS_W-1:0]   pos_q, pos_n;
	logic               ok_q, ok_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [IDX_W-1:0]   idx_q, idx_n;
	pbyte_t             pb_q, pb_n;
	logic [BYTE_W-1:0]  code_hi_q, code_hi_n;
	logic [FLAGS_W-1:0] flags_q, flags_n;
	logic               stop_q, stop_n;
	logic               seq_q, seq_n;
	logic [IDX_W+2:0]   five_idx;

	assign five_idx = (IDX_W+3)'({idx_q, 2'b00}) + (IDX_W+3)'(idx_q);

	always_comb begin
		pos_n     = pos_q;
		ok_n      = ok_q;
		len_n     = len_q;
		idx_n     = idx_q;
		pb_n      = pb_q;
		code_hi_n = code_hi_q;
		flags_n   = flags_q;
		stop_n    = stop_q;
		seq_n     = seq_q;
		if (pos_q < POS_W'(PAGE_BYTES)) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q == POS_W'(0)) begin
				ok_n = (page_byte == PAGE_CODE);
			end else if (pos_q == POS_W'(2)) begin
				len_n = {page_byte, 8'h00};
			end else if (pos_q == POS_W'(3)) begin
				len_n = {len_q[LEN_W-1:BYTE_W], page_byte};
			end else if (pos_q >= POS_W'(4) && !stop_q) begin
				case (pb_q)
					PB_CODE_HI: begin
						if (idx_q >= IDX_W'(MAX_FLAGS) || LEN_W'(five_idx) >= len_q) begin
							stop_n = 1'b1;
						end else begin
							code_hi_n = page_byte;
							pb_n      = PB_CODE_LO;
						end
					end
					PB_CODE_LO: begin
						if ({code_hi_q, page_byte} != LEN_W'(idx_q) + LEN_W'(1)) begin
							stop_n = 1'b1;
							// A broken sequence is only an error before any flag is set.
							seq_n  = (flags_q == '0);
						end else begin
							pb_n = PB_CONTROL;
						end
					end
					PB_CONTROL: begin
						pb_n = PB_LENGTH;
					end
					PB_LENGTH: begin
						if (page_byte != 8'd1) begin
							stop_n = 1'b1;
						end else begin
							pb_n = PB_VALUE;
						end
					end
					PB_VALUE: begin
						if (page_byte != '0) begin
							flags_n = flags_q | (FLAGS_W'(1) << idx_q);
						end
						idx_n = idx_q + IDX_W'(1);
						pb_n  = PB_CODE_HI;
					end
					default: begin
						pb_n = PB_CODE_HI;
					end
				endcase
			end
		end
	end

	assign sum.short_page = (pos_n < POS_W'(4));
	assign sum.code_ok    = ok_n;
	assign sum.seq_err    = seq_n;
	assign sum.count      = idx_n;
	assign sum.flags      = flags_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ok_q      <= 1'b0;
			len_q     <= '0;
			idx_q     <= '0;
			pb_q      <= PB_CODE_HI;
			code_hi_q <= '0;
			flags_q   <= '0;
			stop_q    <= 1'b0;
			seq_q     <= 1'b0;
		end else if (take) begin
			if (last) begin
				pos_q     <= '0;
				ok_q      <= 1'b0;
				len_q     <= '0;
				idx_q     <= '0;
				pb_q      <= PB_CODE_HI;
				code_hi_q <= '0;
				flags_q   <= '0;
				stop_q    <= 1'b0;
				seq_q     <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				ok_q      <= ok_n;
				len_q     <= len_n;
				idx_q     <= idx_n;
				pb_q      <= pb_n;
				code_hi_q <= code_hi_n;
				flags_q   <= flags_n;
				stop_q    <= stop_n;
				seq_q     <= seq_n;
			end
		end
	end

endmodule

/* sv/tlpf_result.sv */
// Result stage: status decision, per-volume seen-flag filter, cleaning bits, output register.
// Depends on tlpf_pkg.
module tlpf_result (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  tlpf_pkg::parse_sum_t           sum,
	input  logic [tlpf_pkg::MEDIA_W-1:0]   media,
	input  logic                           alert_en,
	input  logic                           autoclean_en,
	input  logic                           vendor_clean,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [2:0]                     status,
	output logic [tlpf_pkg::FLAGS_W-1:0]   alert_flags,
	output logic [tlpf_pkg::COUNT_W-1:0]   flag_count,
	output logic                           clean_required,
	output logic                           clean_requested,
	output logic                           cleaning_media_expired,
	output logic                           cleaning_media_invalid,
	output logic                           clean_status_valid
);
	import tlpf_pkg::*;

	logic [FLAGS_W-1:0] seen_flags_q;
	logic [MEDIA_W-1:0] seen_media_q;
	logic               out_valid_q;

	status_t            st;
	logic [FLAGS_W-1:0] flags;
	logic [COUNT_W-1:0] count;
	logic               same_media;
	logic               csv;

	assign same_media = (media == seen_media_q);

	always_comb begin
		flags = '0;
		count = '0;
		if (!alert_en) begin
			st = ST_DISABLED;
		end else if (sum.short_page) begin
			st = ST_SHORT;
		end else if (!sum.code_ok) begin
			st = ST_BAD_CODE;
		end else if (sum.seq_err) begin
			st    = ST_SEQ_ERROR;
			count = COUNT_W'(sum.count);
		end else begin
			flags = sum.flags;
			count = COUNT_W'(sum.count);
			if (sum.flags == '0) begin
				st = ST_NONE_ACTIVE;
			end else if (same_media && (sum.flags & ~seen_flags_q) == '0) begin
				st = ST_ALREADY_SEEN;
			end else begin
				st = ST_NEW_ALERTS;
			end
		end
	end

	assign csv = (st == ST_NEW_ALERTS) && autoclean_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			seen_flags_q <= '0;
			seen_media_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && st == ST_NEW_ALERTS) begin
				// Same volume accumulates; a different volume starts afresh.
				seen_flags_q <= same_media ? (seen_flags_q | sum.flags) : sum.flags;
				seen_media_q <= media;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status                 <= st;
			alert_flags            <= flags;
			flag_count             <= count;
			clean_status_valid     <= csv;
			clean_required         <= csv & flags[BIT_CLEAN_NOW];
			clean_requested        <= csv & (vendor_clean ? flags[BIT_VENDOR_CLEAN]
			                                              : flags[BIT_CLEAN_PERIODIC]);
			cleaning_media_expired <= csv & flags[BIT_EXPIRED_MEDIA];
			cleaning_media_invalid <= csv & flags[BIT_INVALID_MEDIA];
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/tapealert_log_page_filter.sv */
// TapeAlert log page filter, top level: input register, configuration registers,
// parser and result stage. Depends on tlpf_pkg, tlpf_parser, tlpf_result, assert_macros.svh.
//
// The block takes a TapeAlert log page (page code 0x2e) one byte per input transfer,
// starting at byte 0, with last_byte marking the final byte, and gives one result
// transfer per page. It accepts one byte every cycle unless stalled: each byte is
// captured in an input register and consumed by the parser from there, and the
// result of a page is loaded into the output register as its final byte leaves the
// input register. The input side stalls only when a page's final byte sits in the
// input register while the previous result has not yet been taken; bytes that are
// not final keep flowing regardless of the output side.
// Bytes at position PAGE_BYTES and beyond are ignored, at most MAX_FLAGS flag
// parameters are parsed, and alert flags already reported for the mounted volume
// (media_id) are filtered out: status 0 means new alerts, and only then, with
// autoclean enabled, are the cleaning bits meaningful.
// Configuration writes take effect at once and are meant to be made while idle.
module tapealert_log_page_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tlpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic                               cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tlpf_pkg::BYTE_W-1:0]        page_byte,
	input  logic                               last_byte,
	input  logic [tlpf_pkg::MEDIA_W-1:0]       media_id,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic [tlpf_pkg::FLAGS_W-1:0]       alert_flags,
	output logic [tlpf_pkg::COUNT_W-1:0]       flag_count,
	output logic                               clean_required,
	output logic                               clean_requested,
	output logic                               cleaning_media_expired,
	output logic                               cleaning_media_invalid,
	output logic                               clean_status_valid
);
	import tlpf_pkg::*;
	`include "assert_macros.svh"

	// Configuration registers.
	logic alert_en_q;
	logic autoclean_en_q;
	logic vendor_clean_q;

	// Input register.
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;
	logic [MEDIA_W-1:0] media_s1;

	logic       out_free;
	logic       s1_fire;
	logic       in_fire;
	parse_sum_t sum;

	// Summaries of the result used by the checks below.
	logic       clean_any;
	logic       err_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_en_q     <= 1'b0;
			autoclean_en_q <= 1'b0;
			vendor_clean_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALERT_ENABLE:     alert_en_q     <= cfg_wdata;
				CFG_AUTOCLEAN_ENABLE: autoclean_en_q <= cfg_wdata;
				CFG_VENDOR_CLEAN_BIT: vendor_clean_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The output register can take a result if it is empty or being drained.
	assign out_free = !out_valid || out_ready;
	// A non-final byte always moves on; a final byte needs room for its result.
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= page_byte;
			last_s1  <= last_byte;
			media_s1 <= media_id;
		end
	end

	tlpf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (s1_fire),
		.last      (last_s1),
		.page_byte (byte_s1),
		.sum       (sum)
	);

	tlpf_result u_result (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.load                   (s1_fire && last_s1),
		.sum                    (sum),
		.media                  (media_s1),
		.alert_en               (alert_en_q),
		.autoclean_en           (autoclean_en_q),
		.vendor_clean           (vendor_clean_q),
		.out_ready              (out_ready),
		.out_valid              (out_valid),
		.status                 (status),
		.alert_flags            (alert_flags),
		.flag_count             (flag_count),
		.clean_required         (clean_required),
		.clean_requested        (clean_requested),
		.cleaning_media_expired (cleaning_media_expired),
		.cleaning_media_invalid (cleaning_media_invalid),
		.clean_status_valid     (clean_status_valid)
	);

	assign clean_any  = clean_required || clean_requested ||
	                    cleaning_media_expired || cleaning_media_invalid;
	assign err_result = (status == ST_DISABLED) || (status == ST_SHORT) ||
	                    (status == ST_BAD_CODE) || (status == ST_SEQ_ERROR);

	// The input side only stalls behind a final byte waiting on a full output register.
	`CHECK_IMPLY(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && last_s1 && !out_free)
	// A final byte leaving the input register always produces a result.
	`CHECK_NEXT(a_last_gives_result, clk, arst_n, s1_fire && last_s1, out_valid)
	// Cleaning bits are only ever set alongside a valid cleaning status on new alerts.
	`CHECK_IMPLY(a_clean_gated, clk, arst_n, out_valid && clean_any, clean_status_valid)
	// Error and disabled results carry no flags.
	`CHECK_IMPLY(a_err_no_flags, clk, arst_n, out_valid && err_result, alert_flags == '0)

endmodule

/* bench/tapealert_log_page_filter_test.sv */
// Self-checking testbench for tapealert_log_page_filter: builds TapeAlert log pages,
// streams them in byte by byte and checks every result against its own page parser.
// Depends on tlpf_pkg and the RTL of tapealert_log_page_filter.
module tapealert_log_page_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlpf_pkg::*;

	// Offsets of the fields inside one five-byte flag parameter.
	localparam int PRM_CODE_HI = 0;
	localparam int PRM_CODE_LO = 1;
	localparam int PRM_CONTROL = 2;
	localparam int PRM_LENGTH  = 3;
	localparam int PRM_VALUE   = 4;

	// A result reaches the output register once its final byte leaves the input
	// register; settling waits past that before a register write.
	localparam int SETTLE_CYCLES   = 6;
	localparam int LONG_HOLD       = 400;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int MAX_REPORTS     = 50;
	// Byte transfers the whole run aims for; the random phase tops up to it.
	localparam int ITEM_TARGET     = 620;

	// Everything the block should say about one page.
	typedef struct {
		status_t            status;
		logic [FLAGS_W-1:0] flags;
		logic [COUNT_W-1:0] count;
		logic               cln_required;
		logic               cln_requested;
		logic               media_expired;
		logic               media_invalid;
		logic               clean_valid;
	} page_verdict_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ALERT_ENABLE;
	logic                 cfg_wdata = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    page_byte = '0;
	logic                 last_byte = 1'b0;
	logic [MEDIA_W-1:0]   media_id  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           status;
	logic [FLAGS_W-1:0]   alert_flags;
	logic [COUNT_W-1:0]   flag_count;
	logic                 clean_required;
	logic                 clean_requested;
	logic                 cleaning_media_expired;
	logic                 cleaning_media_invalid;
	logic                 clean_status_valid;

	tapealert_log_page_filter dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_wdata              (cfg_wdata),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.page_byte              (page_byte),
		.last_byte              (last_byte),
		.media_id               (media_id),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.status                 (status),
		.alert_flags            (alert_flags),
		.flag_count             (flag_count),
		.clean_required         (clean_required),
		.clean_requested        (clean_requested),
		.cleaning_media_expired (cleaning_media_expired),
		.cleaning_media_invalid (cleaning_media_invalid),
		.clean_status_valid     (clean_status_valid)
	);

	// Our copy of the register settings. Registers are only written while the block is
	// idle, so this mirror can be updated as soon as the write transfer is made.
	logic cfg_alert_en     = 1'b0;
	logic cfg_autoclean    = 1'b0;
	logic cfg_vendor_clean = 1'b0;

	// Our copy of the block's state: the volume filter and the parse of the current page.
	logic [FLAGS_W-1:0] seen_flags = '0;
	logic [MEDIA_W-1:0] seen_media = '0;
	int                 pg_pos     = 0;
	logic [LEN_W-1:0]   pg_add_len = '0;
	logic               pg_code_ok = 1'b0;
	int                 pg_index   = 0;
	int                 pg_field   = PRM_CODE_HI;
	logic [15:0]        pg_code    = '0;
	logic [FLAGS_W-1:0] pg_flags   = '0;
	logic               pg_stopped = 1'b0;
	logic               pg_seq_err = 1'b0;

	page_verdict_t expected_verdicts[$];

	// Page under construction, and the volumes the stimulus picks from.
	logic [BYTE_W-1:0]  page_bytes_q[$];
	logic [MEDIA_W-1:0] media_pool[4];
	logic [MEDIA_W-1:0] cur_media;

	// Sender and receiver behaviour, switched by the tests.
	bit tx_bursty     = 1'b1;
	int tx_burst_left = 0;
	bit rx_stalls     = 1'b1;
	int rx_hold_cycles = 0;

	int mismatches      = 0;
	int results_checked = 0;
	int bytes_moved     = 0;
	int pages_sent      = 0;
	int settings_used   = 0;
	int quiet_cycles    = 0;
	int status_tally[8];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Page parser used for prediction
	// ------------------------------------------------------------------------

	function automatic void restart_page_parse();
		pg_pos     = 0;
		pg_add_len = '0;
		pg_code_ok = 1'b0;
		pg_index   = 0;
		pg_field   = PRM_CODE_HI;
		pg_code    = '0;
		pg_flags   = '0;
		pg_stopped = 1'b0;
		pg_seq_err = 1'b0;
	endfunction

	// One byte of the parameter area. The parse stops for good on the first parameter
	// that is out of bounds, out of sequence or not one byte long.
	function automatic void take_parameter_byte(input logic [BYTE_W-1:0] b);
		case (pg_field)
			PRM_CODE_HI: begin
				if (pg_index >= MAX_FLAGS || 5 * pg_index >= int'(pg_add_len)) begin
					pg_stopped = 1'b1;
				end else begin
					pg_code  = {b, 8'h00};
					pg_field = PRM_CODE_LO;
				end
			end
			PRM_CODE_LO: begin
				pg_code[7:0] = b;
				if (pg_code != 16'(pg_index + 1)) begin
					pg_stopped = 1'b1;
					// Out of sequence before any flag was seen is an error in its own right.
					if (pg_flags == '0)
						pg_seq_err = 1'b1;
				end else begin
					pg_field = PRM_CONTROL;
				end
			end
			PRM_CONTROL: pg_field = PRM_LENGTH;
			PRM_LENGTH: begin
				if (b != 8'd1)
					pg_stopped = 1'b1;
				else
					pg_field = PRM_VALUE;
			end
			default: begin
				if (b != '0)
					pg_flags[pg_index] = 1'b1;
				pg_index++;
				pg_field = PRM_CODE_HI;
			end
		endcase
	endfunction

	// Called for each accepted input transfer; the final byte of a page yields one
	// expected result and restarts the parse.
	function automatic void absorb_page_byte(input logic [BYTE_W-1:0] b, input logic fin,
			input logic [MEDIA_W-1:0] media);
		page_verdict_t v;
		int p;
		p = pg_pos;
		// Bytes beyond the page buffer are dropped without effect.
		if (p < PAGE_BYTES) begin
			pg_pos = p + 1;
			if (p == 0)
				pg_code_ok = (b == PAGE_CODE);
			else if (p == 2)
				pg_add_len = {b, 8'h00};
			else if (p == 3)
				pg_add_len[7:0] = b;
			else if (p >= 4 && !pg_stopped)
				take_parameter_byte(b);
		end
		if (!fin)
			return;

		v.status        = ST_NEW_ALERTS;
		v.flags         = '0;
		v.count         = '0;
		v.cln_required  = 1'b0;
		v.cln_requested = 1'b0;
		v.media_expired = 1'b0;
		v.media_invalid = 1'b0;
		if (!cfg_alert_en) begin
			v.status = ST_DISABLED;
		end else if (pg_pos < 4) begin
			v.status = ST_SHORT;
		end else if (!pg_code_ok) begin
			v.status = ST_BAD_CODE;
		end else if (pg_seq_err) begin
			v.status = ST_SEQ_ERROR;
			v.count  = COUNT_W'(pg_index);
		end else begin
			v.flags = pg_flags;
			v.count = COUNT_W'(pg_index);
			if (pg_flags == '0) begin
				v.status = ST_NONE_ACTIVE;
			end else if (media == seen_media) begin
				// Same volume: only flags not reported before make it news.
				if ((pg_flags & ~seen_flags) == '0) begin
					v.status = ST_ALREADY_SEEN;
				end else begin
					seen_flags |= pg_flags;
					v.status = ST_NEW_ALERTS;
				end
			end else begin
				// A different volume replaces the history.
				seen_flags = pg_flags;
				seen_media = media;
				v.status   = ST_NEW_ALERTS;
			end
		end
		v.clean_valid = (v.status == ST_NEW_ALERTS) && cfg_autoclean;
		if (v.clean_valid) begin
			v.cln_required  = v.flags[BIT_CLEAN_NOW];
			v.cln_requested = cfg_vendor_clean ? v.flags[BIT_VENDOR_CLEAN]
			                                   : v.flags[BIT_CLEAN_PERIODIC];
			v.media_expired = v.flags[BIT_EXPIRED_MEDIA];
			v.media_invalid = v.flags[BIT_INVALID_MEDIA];
		end
		expected_verdicts.push_back(v);
		restart_page_parse();
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: result %0d, %s: got 0x%0h, wanted 0x%0h",
			         $time, results_checked, what, got, want);
	endtask

	task automatic check_result();
		page_verdict_t v;
		if (expected_verdicts.size() == 0) begin
			report_mismatch("result transfer with nothing outstanding, status", status, '0);
			return;
		end
		v = expected_verdicts.pop_front();
		results_checked++;
		status_tally[int'(v.status)]++;
		if (status !== v.status)
			report_mismatch("status", status, v.status);
		if (alert_flags !== v.flags)
			report_mismatch("alert_flags", alert_flags, v.flags);
		if (flag_count !== v.count)
			report_mismatch("flag_count", flag_count, v.count);
		if (clean_required !== v.cln_required)
			report_mismatch("clean_required", clean_required, v.cln_required);
		if (clean_requested !== v.cln_requested)
			report_mismatch("clean_requested", clean_requested, v.cln_requested);
		if (cleaning_media_expired !== v.media_expired)
			report_mismatch("cleaning_media_expired", cleaning_media_expired,
			                v.media_expired);
		if (cleaning_media_invalid !== v.media_invalid)
			report_mismatch("cleaning_media_invalid", cleaning_media_invalid,
			                v.media_invalid);
		if (clean_status_valid !== v.clean_valid)
			report_mismatch("clean_status_valid", clean_status_valid, v.clean_valid);
	endtask

	// Both channels are watched at the rising edge, where every input still holds the
	// value driven at the previous edge. Results are checked before the byte of the
	// same edge is absorbed; with the input register in between, the order is immaterial.
	always @(posedge clk) begin : transfer_monitor
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				absorb_page_byte(page_byte, last_byte, media_id);
				bytes_moved++;
			end
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// The run is abandoned when neither channel has made a transfer for far longer than
	// the longest deliberate stall.
	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
		         quiet_cycles, expected_verdicts.size());
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: either always ready, or alternating runs of ready and stall of random
	// length. A long hold, when requested, keeps out_ready low for the requested stretch
	// so that the block fills up and stalls its input.
	// ------------------------------------------------------------------------

	initial begin : receiver
		int run;
		bit level;
		run   = 0;
		level = 1'b1;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				for (int n = 1; n < rx_hold_cycles; n++)
					@(posedge clk);
				rx_hold_cycles = 0;
				run = 0;
			end else if (!rx_stalls) begin
				out_ready <= 1'b1;
			end else begin
				if (run == 0) begin
					level = !level;
					run = level ? $urandom_range(1, 10) : $urandom_range(1, 8);
				end
				run--;
				out_ready <= level;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Offers one byte and returns at the edge of its transfer, leaving valid high so that
	// a following byte goes out back to back. In bursty mode a random gap precedes each
	// burst of random length.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
			input logic [MEDIA_W-1:0] media);
		int gap;
		if (tx_bursty && tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 24);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (tx_burst_left > 0)
			tx_burst_left--;
		in_valid  <= 1'b1;
		page_byte <= b;
		last_byte <= fin;
		media_id  <= media;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [MEDIA_W-1:0] random_media();
		return media_pool[$urandom_range(0, 3)];
	endfunction

	// The volume name only matters with the final byte; on the others it is noise.
	task automatic send_page(input logic [MEDIA_W-1:0] media);
		int last;
		last = page_bytes_q.size() - 1;
		for (int i = 0; i <= last; i++)
			send_byte(page_bytes_q[i], i == last, (i == last) ? media : random_media());
		pages_sent++;
	endtask

	// Lowers valid and waits until every expected result has arrived, then waits the
	// settling time for bytes that cause no result to leave the pipeline.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers, one per cycle, with the block idle.
	task automatic apply_config(input logic alert, input logic autoclean, input logic vendor);
		wait_until_drained();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ALERT_ENABLE;
		cfg_wdata <= alert;
		@(posedge clk);
		cfg_index <= CFG_AUTOCLEAN_ENABLE;
		cfg_wdata <= autoclean;
		@(posedge clk);
		cfg_index <= CFG_VENDOR_CLEAN_BIT;
		cfg_wdata <= vendor;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_alert_en     = alert;
		cfg_autoclean    = autoclean;
		cfg_vendor_clean = vendor;
		settings_used++;
	endtask

	// ------------------------------------------------------------------------
	// Page construction
	// ------------------------------------------------------------------------

	function automatic int prm(input int k, input int field);
		return 4 + 5 * k + field;
	endfunction

	// A well-formed page of n flag parameters; parameter k carries a nonzero value
	// exactly when bit k of active is set.
	function automatic void build_flag_page(input int n, input logic [63:0] active);
		page_bytes_q = {};
		page_bytes_q.push_back(PAGE_CODE);
		page_bytes_q.push_back(BYTE_W'($urandom));
		page_bytes_q.push_back(BYTE_W'((5 * n) >> 8));
		page_bytes_q.push_back(BYTE_W'(5 * n));
		for (int k = 0; k < n; k++) begin
			page_bytes_q.push_back(BYTE_W'((k + 1) >> 8));
			page_bytes_q.push_back(BYTE_W'(k + 1));
			page_bytes_q.push_back(BYTE_W'($urandom));
			page_bytes_q.push_back(8'd1);
			page_bytes_q.push_back(active[k] ? BYTE_W'($urandom_range(1, 255)) : 8'd0);
		end
	endfunction

	function automatic void cut_page(input int len);
		page_bytes_q = page_bytes_q[0:len-1];
	endfunction

	function automatic void pad_page(input int extra);
		repeat (extra) page_bytes_q.push_back(BYTE_W'($urandom));
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// With alert processing off every page, good or bad, is reported as disabled.
	task automatic test_disabled_pages();
		apply_config(1'b0, 1'b0, 1'b0);
		build_flag_page(1, 64'h1);
		send_page(media_pool[2]);
		page_bytes_q = {8'h00};
		send_page(media_pool[1]);
	endtask

	// Short pages, a wrong page code and pages without any active flag.
	task automatic test_page_framing();
		apply_config(1'b1, 1'b0, 1'b0);
		page_bytes_q = {PAGE_CODE};
		send_page(media_pool[0]);
		build_flag_page(1, 64'h1);
		cut_page(2);
		send_page(media_pool[0]);
		build_flag_page(1, 64'h1);
		cut_page(3);
		send_page(media_pool[0]);
		build_flag_page(1, 64'h1);
		page_bytes_q[0] = ~PAGE_CODE;
		send_page(media_pool[2]);
		build_flag_page(0, 64'h0);
		send_page(media_pool[2]);
		build_flag_page(1, 64'h0);
		send_page(media_pool[2]);
	endtask

	// Parameters out of sequence, of the wrong length, cut short or out of bounds.
	task automatic test_parameter_faults();
		// Out of sequence at the very first parameter: a sequence error.
		build_flag_page(1, 64'h1);
		page_bytes_q[prm(0, PRM_CODE_LO)] = 8'h02;
		send_page(media_pool[1]);
		// Out of sequence after a parameter that carried no flag: still an error.
		build_flag_page(2, 64'h0);
		page_bytes_q[prm(1, PRM_CODE_HI)] = 8'hff;
		send_page(media_pool[1]);
		// Out of sequence once a flag is set merely ends the parse.
		build_flag_page(3, 64'h1);
		page_bytes_q[prm(2, PRM_CODE_LO)] ^= 8'h80;
		send_page(media_pool[1]);
		build_flag_page(2, 64'h3);
		page_bytes_q[prm(1, PRM_LENGTH)] = 8'h00;
		send_page(media_pool[3]);
		build_flag_page(1, 64'h1);
		page_bytes_q[prm(0, PRM_LENGTH)] = 8'hfe;
		send_page(media_pool[2]);
		// A parameter cut short by the end of the page is dropped.
		build_flag_page(2, 64'h3);
		cut_page(page_bytes_q.size() - 2);
		send_page(media_pool[3]);
		// Additional length of 7 admits only two parameters.
		build_flag_page(3, 64'h7);
		page_bytes_q[3] = 8'd7;
		send_page(media_pool[2]);
	endtask

	// Flags already reported for a volume are filtered; a new volume starts afresh.
	task automatic test_seen_filter();
		build_flag_page(1, 64'h1);
		send_page(media_pool[2]);
		build_flag_page(1, 64'h1);
		send_page(media_pool[2]);
		build_flag_page(2, 64'h3);
		send_page(media_pool[2]);
		build_flag_page(2, 64'h2);
		send_page(media_pool[2]);
		build_flag_page(2, 64'h2);
		send_page(media_pool[3]);
		build_flag_page(1, 64'h1);
		send_page(media_pool[2]);
	endtask

	// Cleaning bits with autoclean on, in both vendor modes; they stay low whenever
	// the status is anything but new alerts. The vendor page also overruns the page
	// buffer with the largest additional length, so its tail must be ignored.
	task automatic test_cleaning_bits();
		apply_config(1'b1, 1'b1, 1'b0);
		build_flag_page(23, 64'h0078_0000);
		send_page(media_pool[1]);
		apply_config(1'b1, 1'b1, 1'b1);
		build_flag_page(50, ({$urandom, $urandom} | 64'h0080_0000) & ~64'h0010_0000);
		page_bytes_q[2] = 8'hff;
		page_bytes_q[3] = 8'hff;
		pad_page(8);
		send_page(media_pool[3]);
	endtask

	// The receiver holds off for a long stretch while short pages keep coming, so the
	// block must stall its input; afterwards the sender waits for every result.
	task automatic test_back_pressure();
		tx_bursty = 1'b0;
		rx_hold_cycles = LONG_HOLD;
		repeat (4) begin
			build_flag_page($urandom_range(0, 1), {$urandom, $urandom});
			send_page(random_media());
		end
		wait_until_drained();
		tx_bursty = 1'b1;
	endtask

	// Mostly well-formed short pages with random content, the rest broken in one of
	// several ways, under register settings that change between phases.
	task automatic random_page();
		int n;
		int j;
		logic [63:0] active;
		n = $urandom_range(0, 4);
		case ($urandom_range(0, 3))
			0: active = {$urandom, $urandom};
			1: active = {$urandom, $urandom} & {$urandom, $urandom};
			2: active = '0;
			default: active = '1;
		endcase
		build_flag_page(n, active);
		j = (n > 0) ? $urandom_range(0, n - 1) : 0;
		if ($urandom_range(0, 99) >= 60) begin
			case ($urandom_range(0, 5))
				0: begin
					if (n > 0)
						page_bytes_q[prm(j, $urandom_range(0, 1) ? PRM_CODE_HI : PRM_CODE_LO)]
							^= BYTE_W'($urandom_range(1, 255));
					else
						cut_page($urandom_range(1, 3));
				end
				1: begin
					if (n > 0)
						page_bytes_q[prm(j, PRM_LENGTH)] =
							$urandom_range(0, 1) ? 8'd0 : BYTE_W'($urandom_range(2, 255));
					else
						cut_page($urandom_range(1, 3));
				end
				2: cut_page($urandom_range(1, page_bytes_q.size() - 1));
				3: page_bytes_q[0] ^= BYTE_W'($urandom_range(1, 255));
				4: begin
					page_bytes_q[2] = $urandom_range(0, 3) ? 8'd0 : BYTE_W'($urandom);
					page_bytes_q[3] = BYTE_W'($urandom);
				end
				default: pad_page($urandom_range(1, 12));
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			cur_media = random_media();
		send_page(cur_media);
	endtask

	// Random pages under random settings until the run reaches its byte budget.
	task automatic test_random_pages();
		cur_media = media_pool[2];
		do begin
			apply_config($urandom_range(0, 9) != 0, $urandom_range(0, 1), $urandom_range(0, 1));
			tx_bursty = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			repeat (3) random_page();
		end while (bytes_moved < ITEM_TARGET);
		tx_bursty = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------------

	initial begin : run_tests
		media_pool[0] = '0;
		media_pool[1] = '1;
		media_pool[2] = MEDIA_W'({$urandom, $urandom});
		media_pool[3] = MEDIA_W'({$urandom, $urandom});
		cur_media     = media_pool[2];
		foreach (status_tally[i])
			status_tally[i] = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_pages();
		test_page_framing();
		test_parameter_faults();
		test_seen_filter();
		test_cleaning_bits();
		test_back_pressure();
		test_random_pages();
		// Everything off again at the end.
		apply_config(1'b0, 1'b0, 1'b0);
		build_flag_page(2, 64'h3);
		send_page(media_pool[0]);

		wait_until_drained();
		$display("Covered %0d pages in %0d byte transfers over %0d settings; %0d results.",
		         pages_sent, bytes_moved, settings_used, results_checked);
		$display("Status new %0d, off %0d, none %0d, seen %0d, short %0d, code %0d, seq %0d.",
		         status_tally[ST_NEW_ALERTS], status_tally[ST_DISABLED],
		         status_tally[ST_NONE_ACTIVE], status_tally[ST_ALREADY_SEEN],
		         status_tally[ST_SHORT], status_tally[ST_BAD_CODE],
		         status_tally[ST_SEQ_ERROR]);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
